[design/top_k_score_table_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the top-k score table
// Shared concurrent assertion wrappers, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef TOP_K_SCORE_TABLE_MACROS_SVH
`define TOP_K_SCORE_TABLE_MACROS_SVH

// Checked only while reset is low.
`define TKST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define TKST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/tkst_pkg.sv]
// ----------------------------------------------------------------------------
// tkst_pkg
// Types, sizes and helpers shared by the top-k score table modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tkst_pkg;

  localparam int ENTRIES = 10;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int RANK_W  = 4;
  localparam int VAL_W   = 16;

  localparam logic [CNT_W-1:0] ENTRIES_CNT = CNT_W'(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(ENTRIES - 1);

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  typedef struct packed {
    logic [VAL_W-1:0] kills;
    logic [VAL_W-1:0] score;
    logic [VAL_W-1:0] tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
  } mem_req_t;

  typedef struct packed {
    logic [RANK_W-1:0] placed_rank;
    logic              dropped;
    logic              entry_valid;
    logic [VAL_W-1:0]  out_tag;
    logic [VAL_W-1:0]  out_score;
    logic [VAL_W-1:0]  out_kills;
    logic [RANK_W-1:0] entry_count;
  } res_t;

  // A count narrowed or widened to the four-bit result field.
  function automatic logic [RANK_W-1:0] cnt_to_field(input logic [CNT_W-1:0] c);
    logic [CNT_W+RANK_W-1:0] e;
    e = {{RANK_W{1'b0}}, c};
    return e[RANK_W-1:0];
  endfunction

  // A requested rank as a table index; only used once it is known in range.
  function automatic logic [IDX_W-1:0] rank_to_idx(input logic [RANK_W-1:0] r);
    logic [IDX_W+RANK_W-1:0] e;
    e = {{IDX_W{1'b0}}, r};
    return e[IDX_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] idx_to_cnt(input logic [IDX_W-1:0] i);
    logic [CNT_W+IDX_W-1:0] e;
    e = {{CNT_W{1'b0}}, i};
    return e[CNT_W-1:0];
  endfunction

  function automatic logic rank_below(input logic [RANK_W-1:0] r,
                                      input logic [CNT_W-1:0]  c);
    logic [CNT_W+RANK_W-1:0] er;
    logic [CNT_W+RANK_W-1:0] ec;
    er = {{CNT_W{1'b0}}, r};
    ec = {{RANK_W{1'b0}}, c};
    return er < ec;
  endfunction

endpackage

`default_nettype wire

[design/tkst_ram.sv]
// ----------------------------------------------------------------------------
// tkst_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tkst_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 10,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[design/tkst_seq.sv]
// ----------------------------------------------------------------------------
// tkst_seq
// Sequencer: insert scans from the bottom, shifts down, places; read fetches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "top_k_score_table_macros.svh"

module tkst_seq
  import tkst_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_mode,
  input  wire logic [VAL_W-1:0]  in_tag,
  input  wire logic [VAL_W-1:0]  in_score,
  input  wire logic [VAL_W-1:0]  in_kills,
  input  wire logic [RANK_W-1:0] in_rank,
  output mem_req_t               mem_req,
  input  wire entry_t            rd_data,
  output res_t                   res,
  output logic                   res_valid,
  input  wire logic              res_ready
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_RDWAIT = 5'b00100,
    S_PLACE  = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] valid_count, valid_count_next;
  logic [IDX_W-1:0] scan_idx, scan_idx_next;
  logic [CNT_W-1:0] pos, pos_next;
  res_t             res_next;
  entry_t           item;
  logic [CNT_W-1:0] count_m1;

  assign count_m1  = valid_count - 1'b1;
  assign res_valid = (state == S_DONE);

  always_comb begin
    state_next       = state;
    valid_count_next = valid_count;
    scan_idx_next    = scan_idx;
    pos_next         = pos;
    res_next         = res;
    mem_req          = '0;
    in_ready         = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          res_next             = '0;
          res_next.placed_rank = cnt_to_field(ENTRIES_CNT);
          res_next.entry_count = cnt_to_field(valid_count);
          if (in_mode == MODE_INSERT) begin
            if (valid_count == '0) begin
              pos_next   = '0;
              state_next = S_PLACE;
            end else begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = count_m1[IDX_W-1:0];
              scan_idx_next   = count_m1[IDX_W-1:0];
              state_next      = S_SCAN;
            end
          end else if (rank_below(in_rank, valid_count)) begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = rank_to_idx(in_rank);
            state_next      = S_RDWAIT;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SCAN: begin
        // rd_data holds the entry at scan_idx; lower scores move down one place.
        if (rd_data.score < item.score) begin
          if (scan_idx != LAST_IDX) begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = scan_idx + 1'b1;
            mem_req.wr_data = rd_data;
          end
          if (scan_idx == '0) begin
            pos_next   = '0;
            state_next = S_PLACE;
          end else begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = scan_idx - 1'b1;
            scan_idx_next   = scan_idx - 1'b1;
          end
        end else begin
          pos_next   = idx_to_cnt(scan_idx) + 1'b1;
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        // A full table with nothing lower than the new score leaves pos at ENTRIES.
        if (pos != ENTRIES_CNT) begin
          mem_req.wr_en        = 1'b1;
          mem_req.wr_addr      = pos[IDX_W-1:0];
          mem_req.wr_data      = item;
          res_next.placed_rank = cnt_to_field(pos);
          res_next.dropped     = (valid_count == ENTRIES_CNT);
          if (valid_count != ENTRIES_CNT) begin
            valid_count_next     = valid_count + 1'b1;
            res_next.entry_count = cnt_to_field(valid_count + 1'b1);
          end
        end
        state_next = S_DONE;
      end
      S_RDWAIT: begin
        res_next.entry_valid = 1'b1;
        res_next.out_tag     = rd_data.tag;
        res_next.out_score   = rd_data.score;
        res_next.out_kills   = rd_data.kills;
        state_next           = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      valid_count <= '0;
    end else begin
      state       <= state_next;
      valid_count <= valid_count_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx <= scan_idx_next;
    pos      <= pos_next;
    res      <= res_next;
    if (in_valid && in_ready) begin
      item.tag   <= in_tag;
      item.score <= in_score;
      item.kills <= in_kills;
    end
  end

  `TKST_ASSERT(a_reset_idle, $past(rst) |-> state == S_IDLE, "not idle after reset")
  `TKST_ASSERT(a_count_max, valid_count <= ENTRIES_CNT, "entry count above table size")
  `TKST_ASSERT(a_port_clash, mem_req.rd_en && mem_req.wr_en |-> mem_req.rd_addr != mem_req.wr_addr, "read and write hit the same entry")
  `TKST_ASSERT(a_unplaced_no_drop, res_valid && res.placed_rank == cnt_to_field(ENTRIES_CNT) |-> !res.dropped, "drop reported for an entry that was not placed")
  `TKST_ASSERT(a_count_step, valid_count != $past(valid_count) |-> $past(state) == S_PLACE && valid_count == $past(valid_count) + 1'b1, "entry count changed outside placement")

endmodule

`default_nettype wire

[design/top_k_score_table.sv]
// ----------------------------------------------------------------------------
// top_k_score_table
// Table of the best-scoring entries kept in descending score order.
// ----------------------------------------------------------------------------
//  Channel   Dir  Content
//  s_axis    in   tuser: mode; tdata: player_tag, new_score, new_kills, read_rank
//  m_axis    out  tdata: placed_rank, dropped, entry_valid, out_tag, out_score,
//                 out_kills, entry_count
//
// An insert scans the valid entries, if any, and then places the new entry:
// the scan reads one table entry per cycle from the bottom of the valid entries
// through the single read port of the table RAM, moving lower scores down.
// A read returns the ranked entry, or none if the rank is not below the entry count.
// One transaction is in work at a time.
// The result register lets the next transaction be accepted while a result waits.
// Reset empties the table at once by clearing the entry count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module top_k_score_table
  import tkst_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,  // player_tag, new_score, new_kills, read_rank, pad
  input  wire logic [0:0]  s_axis_tuser,  // mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata   // placed_rank, dropped, entry_valid, out_tag,
                                          // out_score, out_kills, entry_count, pad
);

  mem_req_t mem_req;
  entry_t   rd_data;
  logic [ENTRY_W-1:0] rd_word;
  res_t     res;
  logic     res_valid;
  logic     res_ready;

  tkst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES),
    .AW    (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (rd_word)
  );

  assign rd_data = rd_word;

  tkst_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_mode   (s_axis_tuser[0]),
    .in_tag    (s_axis_tdata[15:0]),
    .in_score  (s_axis_tdata[31:16]),
    .in_kills  (s_axis_tdata[47:32]),
    .in_rank   (s_axis_tdata[51:48]),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready)
  );

  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_axis_tdata <= {6'b0, res.entry_count, res.out_kills, res.out_score,
                       res.out_tag, res.entry_valid, res.dropped, res.placed_rank};
    end
  end

endmodule

`default_nettype wire

[test/testbench.sv]
// ----------------------------------------------------------------------------
// Testbench for top_k_score_table
// A queue of inserts and reads is driven into the slave stream with random
// gaps. An in-bench ranking model predicts every result at acceptance. The
// master stream is stalled at random, and each result is checked field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  import tkst_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_OPS  = 1900;

  typedef struct {
    logic              mode;
    logic [VAL_W-1:0]  tag;
    logic [VAL_W-1:0]  score;
    logic [VAL_W-1:0]  kills;
    logic [RANK_W-1:0] rank;
    bit                hold;   // wait for the table to go quiet first
  } board_op_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;  // player_tag, new_score, new_kills, read_rank, pad
  logic [0:0]  s_axis_tuser = '0;  // mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;       // placed_rank, dropped, entry_valid, out_tag,
                                   // out_score, out_kills, entry_count, pad

  board_op_t board_ops[$];
  res_t      awaited_results[$];

  // Model of the table contents.
  entry_t board[ENTRIES];
  int     held = 0;

  int  mismatches = 0;
  int  cycles = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  logic calm = 1'b0;

  top_k_score_table u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one operation to the model and returns the result it should give.
  function automatic res_t update_leaderboard(input board_op_t op);
    res_t r;
    int   pos;
    int   last;
    int   i;
    r = '0;
    r.placed_rank = RANK_W'(ENTRIES);
    if (op.mode == MODE_INSERT) begin
      // New entry goes below every entry with an equal or higher score.
      pos = 0;
      while (pos < held && board[pos].score >= op.score) pos++;
      if (pos < ENTRIES) begin
        if (held == ENTRIES) begin
          r.dropped = 1'b1;
          last = ENTRIES - 1;
        end else begin
          last = held;
          held++;
        end
        for (i = last; i > pos; i--) board[i] = board[i-1];
        board[pos].tag = op.tag;
        board[pos].score = op.score;
        board[pos].kills = op.kills;
        r.placed_rank = RANK_W'(pos);
      end
    end else if (int'(op.rank) < held) begin
      r.entry_valid = 1'b1;
      r.out_tag = board[op.rank].tag;
      r.out_score = board[op.rank].score;
      r.out_kills = board[op.rank].kills;
    end
    r.entry_count = RANK_W'(held);
    return r;
  endfunction

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void check_field(input string what, input longint want,
                                      input longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  task automatic add_insert(input logic [15:0] tag, input logic [15:0] score,
                            input logic [15:0] kills);
    board_op_t op;
    op = '{mode: MODE_INSERT, tag: tag, score: score, kills: kills, rank: '0, hold: 1'b0};
    board_ops.push_back(op);
  endtask

  task automatic add_read(input logic [3:0] rank);
    board_op_t op;
    op = '{mode: MODE_READ, tag: 16'($urandom), score: 16'($urandom),
           kills: 16'($urandom), rank: rank, hold: 1'b0};
    board_ops.push_back(op);
  endtask

  // Driver: a new transaction is presented only once the previous one is taken.
  always @(posedge clk) begin
    board_op_t op;
    logic      fire;
    fire = s_axis_tvalid && s_axis_tready;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (fire) begin
        awaited_results.push_back(update_leaderboard(board_ops.pop_front()));
        gap_left = pick_pause();
      end
      if (!s_axis_tvalid || fire) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (board_ops.size() > 0 &&
                     !(board_ops[0].hold && awaited_results.size() > 0)) begin
          op = board_ops[0];
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {4'b0, op.rank, op.kills, op.score, op.tag};
          s_axis_tuser <= op.mode;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result and stalls the master side at random.
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected, expected nothing, got %h",
                   $time, m_axis_tdata);
        end else begin
          want = awaited_results.pop_front();
          check_field("placed_rank", want.placed_rank, m_axis_tdata[3:0]);
          check_field("dropped", want.dropped, m_axis_tdata[4]);
          check_field("entry_valid", want.entry_valid, m_axis_tdata[5]);
          check_field("out_tag", want.out_tag, m_axis_tdata[21:6]);
          check_field("out_score", want.out_score, m_axis_tdata[37:22]);
          check_field("out_kills", want.out_kills, m_axis_tdata[53:38]);
          check_field("entry_count", want.entry_count, m_axis_tdata[57:54]);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        stall_left = ($urandom_range(0, 3) == 0) ? pick_pause() : 0;
        m_axis_tready <= (stall_left == 0);
      end
    end
  end

  // Run length guard; also switches between calm and gappy stretches.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles % 256 == 0) calm <= ($urandom_range(0, 3) == 0);
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int          k;
    int          pick;
    int          drift;
    logic [15:0] score;
    logic [15:0] kills;

    // Reads of an empty table.
    add_read(4'd0);
    add_read(4'd9);
    // Score extremes, and ties that must keep their arrival order.
    add_insert(16'h0000, 16'h0000, 16'h0000);
    add_insert(16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_insert(16'h0001, 16'hFFFF, 16'h0001);
    add_insert(16'h0002, 16'h0000, 16'h0002);
    for (k = 0; k < 5; k++) add_read(k[3:0]);
    // Fill the table.
    add_insert(16'h0010, 16'd1000, 16'h1234);
    add_insert(16'h0011, 16'd2000, 16'h8000);
    add_insert(16'h0012, 16'd500, 16'h00FF);
    add_insert(16'h0013, 16'd3000, 16'h7FFF);
    add_insert(16'h0014, 16'd1000, 16'hFF00);
    add_insert(16'h0015, 16'd7, 16'h0F0F);
    // Full table: equal to the last score is rejected, above it drops one.
    add_insert(16'h0020, 16'h0000, 16'h0003);
    add_insert(16'h0021, 16'h0001, 16'h0004);
    add_insert(16'h0022, 16'h0000, 16'h0005);
    add_insert(16'h5555, 16'h8000, 16'hAAAA);
    add_read(4'd9);
    add_read(4'd0);

    // Scores drift upward so that inserts keep landing inside a full table.
    for (k = 0; k < RANDOM_OPS; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        add_read(4'($urandom_range(0, ENTRIES - 1)));
      end else begin
        drift = k * 30 + $urandom_range(0, 4000);
        pick = $urandom_range(0, 99);
        if (pick < 50) score = 16'(drift);
        else if (pick < 75) score = 16'(drift) & 16'hFC00;  // coarse grid gives ties
        else if (pick < 90) score = 16'($urandom);
        else score = 16'h0000;
        pick = $urandom_range(0, 9);
        kills = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
        add_insert(16'($urandom), score, kills);
      end
      if (k == RANDOM_OPS / 2) board_ops[$].hold = 1;
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (board_ops.size() != 0 || s_axis_tvalid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
